// ----- rtl/cacr_pkg.sv -----
package cacr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS = 24;
  localparam int LENGTH_BITS = 20;
  localparam int STEP_BITS = 24;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_START_RAMP_SAMPLES = 100;
  localparam int DEF_POSITION_BITS = 20;

  localparam logic [GAIN_BITS-1:0] GAIN_MAX = {GAIN_BITS{1'b1}};

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK_STEP = 1'd1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } req_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } rsp_item_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] attack_length;
    logic [STEP_BITS-1:0]   attack_step;
  } cfg_t;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_TRIGGER
  } cmd_kind_t;

  // samples are kept as sign and magnitude for the unsigned multiplier
  typedef struct packed {
    cmd_kind_t              kind;
    logic                   left_neg;
    logic [SAMPLE_BITS-1:0] left_mag;
    logic                   right_neg;
    logic [SAMPLE_BITS-1:0] right_mag;
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ATTACK,
    MODE_START
  } ramp_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SQUARE,
    ST_CUBE,
    ST_LEFT,
    ST_RIGHT,
    ST_HOLD
  } back_state_t;

  function automatic logic [SAMPLE_BITS-1:0] cond_negate(
    input logic                   neg,
    input logic [SAMPLE_BITS-1:0] v
  );
    cond_negate = neg ? (SAMPLE_BITS'(0) - v) : v;
  endfunction

endpackage

// ----- rtl/cacr_front.sv -----
module cacr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cacr_pkg::req_item_t  req,
  output logic                 cmd_valid,
  input  logic                 cmd_pop,
  output cacr_pkg::cmd_t       cmd
);

  localparam int DEPTH = cacr_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cacr_pkg::cmd_t entries [DEPTH];
  cacr_pkg::cmd_t cmd_in;
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic [cacr_pkg::SAMPLE_BITS-1:0] left_raw;
  logic [cacr_pkg::SAMPLE_BITS-1:0] right_raw;
  logic push;
  logic pop;

  assign left_raw = req.left_in;
  assign right_raw = req.right_in;

  // classify the beat and split samples into sign and magnitude
  always_comb begin
    cmd_in.kind = (req.req_type == cacr_pkg::REQ_TRIGGER) ? cacr_pkg::CMD_TRIGGER
                                                         : cacr_pkg::CMD_SAMPLE;
    cmd_in.left_neg = left_raw[cacr_pkg::SAMPLE_BITS-1];
    cmd_in.left_mag = cacr_pkg::cond_negate(left_raw[cacr_pkg::SAMPLE_BITS-1], left_raw);
    cmd_in.right_neg = right_raw[cacr_pkg::SAMPLE_BITS-1];
    cmd_in.right_mag = cacr_pkg::cond_negate(right_raw[cacr_pkg::SAMPLE_BITS-1], right_raw);
  end

  assign req_ready = (count != CNT_BITS'(DEPTH));
  assign cmd_valid = (count != CNT_BITS'(0));
  assign push = req_valid && req_ready;
  assign pop = cmd_pop && cmd_valid;
  assign cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ----- rtl/cacr_back.sv -----
module cacr_back #(
  parameter int START_RAMP_SAMPLES = cacr_pkg::DEF_START_RAMP_SAMPLES,
  parameter int POSITION_BITS = cacr_pkg::DEF_POSITION_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cacr_pkg::cfg_t       cfg,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  cacr_pkg::cmd_t       cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cacr_pkg::rsp_item_t  rsp
);

  localparam int G = cacr_pkg::GAIN_BITS;
  localparam int AW = (POSITION_BITS > G) ? POSITION_BITS : G;
  localparam int BW = G + 1;
  localparam int PW = AW + BW;
  localparam int LIM_BITS = (cacr_pkg::LENGTH_BITS > 17) ? cacr_pkg::LENGTH_BITS : 17;
  localparam int CW = (POSITION_BITS + 1 > LIM_BITS) ? POSITION_BITS + 1 : LIM_BITS;
  localparam logic [BW-1:0] GAIN_ONE = BW'(1) << G;
  localparam logic [BW-1:0] START_STEP = BW'(GAIN_ONE / START_RAMP_SAMPLES);

  cacr_pkg::back_state_t state, state_next;
  cacr_pkg::ramp_mode_t  mode;
  cacr_pkg::cmd_t        cur;
  logic [POSITION_BITS-1:0] pos;
  logic [G-1:0] gain;
  logic [G-1:0] gain_sq;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [G-1:0] prod_hi;
  logic [G-1:0] gain_sat;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] limit;

  assign prod = PW'(mul_a) * PW'(mul_b);
  assign prod_hi = prod[2*G-1:G];
  assign gain_sat = (prod > PW'(cacr_pkg::GAIN_MAX)) ? cacr_pkg::GAIN_MAX : prod[G-1:0];
  assign pos_inc = CW'(pos) + CW'(1);
  assign limit = (mode == cacr_pkg::MODE_ATTACK) ? CW'(cfg.attack_length)
                                                : CW'(START_RAMP_SAMPLES);

  always_comb begin
    state_next = state;
    unique case (state)
      cacr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == cacr_pkg::CMD_TRIGGER) begin
            state_next = cacr_pkg::ST_IDLE;
          end else if (mode == cacr_pkg::MODE_NONE) begin
            state_next = cacr_pkg::ST_HOLD;
          end else begin
            state_next = cacr_pkg::ST_GAIN;
          end
        end
      end
      cacr_pkg::ST_GAIN: begin
        state_next = (mode == cacr_pkg::MODE_ATTACK) ? cacr_pkg::ST_SQUARE
                                                     : cacr_pkg::ST_LEFT;
      end
      cacr_pkg::ST_SQUARE: state_next = cacr_pkg::ST_CUBE;
      cacr_pkg::ST_CUBE:   state_next = cacr_pkg::ST_LEFT;
      cacr_pkg::ST_LEFT:   state_next = cacr_pkg::ST_RIGHT;
      cacr_pkg::ST_RIGHT:  state_next = cacr_pkg::ST_HOLD;
      cacr_pkg::ST_HOLD: begin
        if (rsp_ready) begin
          state_next = cacr_pkg::ST_IDLE;
        end
      end
      default: state_next = cacr_pkg::ST_IDLE;
    endcase
  end

  // operand steering for the shared multiplier
  always_comb begin
    cmd_pop = 1'b0;
    rsp_valid = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      cacr_pkg::ST_IDLE: cmd_pop = cmd_valid;
      cacr_pkg::ST_GAIN: begin
        mul_a = AW'(pos);
        mul_b = (mode == cacr_pkg::MODE_ATTACK) ? BW'(cfg.attack_step) : START_STEP;
      end
      cacr_pkg::ST_SQUARE: begin
        mul_a = AW'(gain);
        mul_b = BW'(gain);
      end
      cacr_pkg::ST_CUBE: begin
        mul_a = AW'(gain_sq);
        mul_b = BW'(gain);
      end
      cacr_pkg::ST_LEFT: begin
        mul_a = AW'(cur.left_mag);
        mul_b = BW'(gain);
      end
      cacr_pkg::ST_RIGHT: begin
        mul_a = AW'(cur.right_mag);
        mul_b = BW'(gain);
      end
      cacr_pkg::ST_HOLD: rsp_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cacr_pkg::ST_IDLE;
      mode <= cacr_pkg::MODE_NONE;
      pos <= '0;
    end else begin
      state <= state_next;
      if (state == cacr_pkg::ST_IDLE && cmd_valid && cmd.kind == cacr_pkg::CMD_TRIGGER) begin
        mode <= (cfg.attack_length != '0) ? cacr_pkg::MODE_ATTACK : cacr_pkg::MODE_START;
        pos <= '0;
      end
      if (state == cacr_pkg::ST_RIGHT) begin
        pos <= pos_inc[POSITION_BITS-1:0];
        if (pos_inc >= limit) begin
          mode <= cacr_pkg::MODE_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cacr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cur <= cmd;
          // pass-through when no ramp runs
          rsp.left_out <= signed'(cacr_pkg::cond_negate(cmd.left_neg, cmd.left_mag));
          rsp.right_out <= signed'(cacr_pkg::cond_negate(cmd.right_neg, cmd.right_mag));
        end
      end
      cacr_pkg::ST_GAIN:   gain <= gain_sat;
      cacr_pkg::ST_SQUARE: gain_sq <= prod_hi;
      cacr_pkg::ST_CUBE:   gain <= prod_hi;
      cacr_pkg::ST_LEFT:   rsp.left_out <= signed'(cacr_pkg::cond_negate(cur.left_neg, prod_hi));
      cacr_pkg::ST_RIGHT:  rsp.right_out <= signed'(cacr_pkg::cond_negate(cur.right_neg, prod_hi));
      default: ;
    endcase
  end

endmodule

// ----- rtl/cubic_attack_click_ramp.sv -----
// stereo envelope gain with a cubic attack or a short linear start ramp
// req channel (req_valid/req_ready/req): one beat is either a trigger
// (req_type 1) or a stereo sample pair (req_type 0); rsp channel
// (rsp_valid/rsp_ready/rsp) carries one gained sample pair per sample beat,
// triggers give no beat. cfg_we/cfg_index/cfg_data write attack_length
// (index 0) and attack_step (index 1, Q0.24 reciprocal of the length).
// a front queue of two entries takes beats and splits samples into sign and
// magnitude; a back sequencer runs all products through one shared multiplier.
// the back sequencer steps that multiplier one item at a time: a trigger
// is taken in idle and gives no result, a sample with no ramp goes
// straight to hold, a start ramp sample computes its gain and then the left
// and right products, and an attack sample computes gain, square and cube
// before left and right; each result then waits in hold for rsp_ready.
// when the receiver stalls the result holds in rsp and the queue keeps
// taking beats until its two entries are full, then req_ready drops.
// reset clears both registers, the queue and the ramp (no ramp active).
module cubic_attack_click_ramp #(
  parameter int START_RAMP_SAMPLES = cacr_pkg::DEF_START_RAMP_SAMPLES,
  parameter int POSITION_BITS = cacr_pkg::DEF_POSITION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  cacr_pkg::req_item_t                   req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output cacr_pkg::rsp_item_t                   rsp,
  input  logic                                  cfg_we,
  input  logic [cacr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [cacr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  cacr_pkg::cfg_t cfg;
  cacr_pkg::cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_length <= '0;
      cfg.attack_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cacr_pkg::CFG_ATTACK_LENGTH:
          cfg.attack_length <= cfg_data[cacr_pkg::LENGTH_BITS-1:0];
        cacr_pkg::CFG_ATTACK_STEP:
          cfg.attack_step <= cfg_data[cacr_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  cacr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  cacr_back #(
    .START_RAMP_SAMPLES (START_RAMP_SAMPLES),
    .POSITION_BITS      (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1650;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD = 400;
  localparam int MAX_PRINTS = 40;
  localparam int START_RAMP_LEN = cacr_pkg::DEF_START_RAMP_SAMPLES;
  localparam longint unsigned START_STEP = 64'd16777216 / START_RAMP_LEN;
  localparam int SB = cacr_pkg::SAMPLE_BITS;
  localparam int PB = cacr_pkg::DEF_POSITION_BITS;

  localparam int RX_ALWAYS = 0;
  localparam int RX_COIN = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_MOSTLY = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  cacr_pkg::req_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  cacr_pkg::rsp_item_t rsp;
  logic cfg_we = 1'b0;
  logic [cacr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [cacr_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // envelope state mirrored from the block
  logic [cacr_pkg::LENGTH_BITS-1:0] atk_len = '0;
  logic [cacr_pkg::STEP_BITS-1:0] atk_step = '0;
  cacr_pkg::ramp_mode_t env_mode = cacr_pkg::MODE_NONE;
  logic [PB-1:0] env_pos = '0;

  cacr_pkg::req_item_t pending_beats[$];
  cacr_pkg::rsp_item_t gained_pairs[$];
  cacr_pkg::rsp_item_t want;

  int errors = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_left = 0;
  int tx_gapless = 0;
  int rx_style = RX_ALWAYS;
  int rx_tick = 0;
  int hold_left = 0;
  int hold_start = 0;

  cubic_attack_click_ramp dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic longint unsigned clamp_gain(longint unsigned g);
    return (g > 64'(cacr_pkg::GAIN_MAX)) ? 64'(cacr_pkg::GAIN_MAX) : g;
  endfunction

  // sign-magnitude multiply, truncated toward zero
  function automatic logic [SB-1:0] scale_sample(
    logic signed [SB-1:0] s,
    longint unsigned g
  );
    longint v;
    longint unsigned mag;
    longint unsigned prod;
    v = s;
    mag = (v < 0) ? -v : v;
    prod = (mag * g) >> 24;
    return (v < 0) ? SB'(-prod) : SB'(prod);
  endfunction

  function automatic void envelope_predict(cacr_pkg::req_item_t b);
    longint unsigned g;
    logic [PB:0] nxt;
    cacr_pkg::rsp_item_t r;
    if (b.req_type == cacr_pkg::REQ_TRIGGER) begin
      env_mode = (atk_len != 0) ? cacr_pkg::MODE_ATTACK : cacr_pkg::MODE_START;
      env_pos = '0;
      return;
    end
    r.left_out = b.left_in;
    r.right_out = b.right_in;
    nxt = {1'b0, env_pos} + 1'b1;
    if (env_mode == cacr_pkg::MODE_ATTACK) begin
      g = clamp_gain(64'(env_pos) * 64'(atk_step));
      g = clamp_gain((((g * g) >> 24) * g) >> 24);
      r.left_out = scale_sample(b.left_in, g);
      r.right_out = scale_sample(b.right_in, g);
      if (nxt >= {1'b0, atk_len}) env_mode = cacr_pkg::MODE_NONE;
      env_pos = nxt[PB-1:0];
    end else if (env_mode == cacr_pkg::MODE_START) begin
      g = clamp_gain(64'(env_pos) * START_STEP);
      r.left_out = scale_sample(b.left_in, g);
      r.right_out = scale_sample(b.right_in, g);
      if (nxt >= START_RAMP_LEN) env_mode = cacr_pkg::MODE_NONE;
      env_pos = nxt[PB-1:0];
    end
    gained_pairs.push_back(r);
  endfunction

  function automatic void push_beat(logic kind, logic [SB-1:0] l, logic [SB-1:0] r);
    cacr_pkg::req_item_t b;
    b.req_type = kind;
    b.left_in = l;
    b.right_in = r;
    pending_beats.push_back(b);
    items_sent++;
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      4: return 24'h000001;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [cacr_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [cacr_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cacr_pkg::CFG_ATTACK_LENGTH) atk_len = val[cacr_pkg::LENGTH_BITS-1:0];
    else atk_step = val[cacr_pkg::STEP_BITS-1:0];
  endtask

  // wait until every beat is in and every result is out, then let
  // trailing triggers clear the block
  task automatic settle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || req_valid || gained_pairs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (req_valid && req_ready) begin
        envelope_predict(req);
        void'(pending_beats.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = tx_gapless ? 0 : $urandom_range(1, 9);
        end
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_valid <= 1'b0;
        end else begin
          req_valid <= 1'b1;
          req <= pending_beats[0];
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left = 0;
      rx_tick = 0;
    end else begin
      if (hold_start != 0) begin
        hold_start = 0;
        hold_left = LONG_HOLD;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: rsp_ready <= 1'b1;
          RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: rsp_ready <= (rx_tick % 5) < 2;
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (gained_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat left=%h right=%h",
                                  rsp.left_out, rsp.right_out));
      end else begin
        want = gained_pairs.pop_front();
        if (rsp.left_out !== want.left_out)
          report_mismatch($sformatf("left_out got %h want %h", rsp.left_out, want.left_out));
        if (rsp.right_out !== want.right_out)
          report_mismatch($sformatf("right_out got %h want %h", rsp.right_out, want.right_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase;
    int phase_items;
    int phase_target;
    int span;
    int run;
    logic [cacr_pkg::LENGTH_BITS-1:0] len;
    logic [cacr_pkg::STEP_BITS-1:0] step;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no ramp after reset: samples pass through, then the start ramp
    rx_style = RX_COIN;
    @(negedge clk);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h000000, 24'hFFFFFF);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h000001, 24'h800001);
    push_beat(cacr_pkg::REQ_TRIGGER, 24'hFFFFFF, 24'hFFFFFF);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h123456, 24'hFFFFFF);
    // retrigger in the middle of the ramp
    push_beat(cacr_pkg::REQ_TRIGGER, 24'h000000, 24'h000000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h800000, 24'h7FFFFF);
    settle();

    write_reg(cacr_pkg::CFG_ATTACK_LENGTH, 24'd4);
    write_reg(cacr_pkg::CFG_ATTACK_STEP, 24'h400000);
    @(negedge clk);
    push_beat(cacr_pkg::REQ_TRIGGER, 24'h000000, 24'h000000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h800000, 24'h7FFFFF);
    settle();

    // length cut to zero while the attack runs: one more gained beat
    write_reg(cacr_pkg::CFG_ATTACK_LENGTH, 24'd0);
    @(negedge clk);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    settle();

    // step far too large for the length: gain saturates
    write_reg(cacr_pkg::CFG_ATTACK_LENGTH, 24'd3);
    write_reg(cacr_pkg::CFG_ATTACK_STEP, 24'hFFFFFF);
    @(negedge clk);
    push_beat(cacr_pkg::REQ_TRIGGER, 24'h000000, 24'h000000);
    repeat (4) push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    settle();

    write_reg(cacr_pkg::CFG_ATTACK_LENGTH, 24'd1);
    write_reg(cacr_pkg::CFG_ATTACK_STEP, 24'd0);
    @(negedge clk);
    push_beat(cacr_pkg::REQ_TRIGGER, 24'h000000, 24'h000000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    settle();

    write_reg(cacr_pkg::CFG_ATTACK_LENGTH, 24'h0FFFFF);
    write_reg(cacr_pkg::CFG_ATTACK_STEP, 24'd16);
    @(negedge clk);
    push_beat(cacr_pkg::REQ_TRIGGER, 24'h000000, 24'h000000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000);
    push_beat(cacr_pkg::REQ_SAMPLE, 24'h800000, 24'h7FFFFF);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      phase++;
      case ($urandom_range(0, 7))
        0: len = '0;
        1: len = cacr_pkg::LENGTH_BITS'($urandom_range(1, 4));
        2, 3: len = cacr_pkg::LENGTH_BITS'($urandom_range(5, 160));
        4: len = cacr_pkg::LENGTH_BITS'($urandom_range(161, 400));
        5: len = '1;
        6: len = cacr_pkg::LENGTH_BITS'($urandom_range(0, 20'hFFFFF));
        default: len = cacr_pkg::LENGTH_BITS'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 9))
        0: step = '0;
        1: step = '1;
        2: step = cacr_pkg::STEP_BITS'($urandom);
        default: step = (len <= 1) ? '1 : cacr_pkg::STEP_BITS'(32'h1000000 / len);
      endcase
      // sometimes keep a stale register so mismatched pairs show up
      if ($urandom_range(0, 5) != 0)
        write_reg(cacr_pkg::CFG_ATTACK_LENGTH, cacr_pkg::CFG_DATA_BITS'(len));
      if ($urandom_range(0, 5) != 0) write_reg(cacr_pkg::CFG_ATTACK_STEP, step);
      rx_style = $urandom_range(RX_ALWAYS, RX_MOSTLY);
      tx_gapless = ($urandom_range(0, 3) == 0);
      @(negedge clk);
      // long receiver hold-off while the sender keeps offering beats
      if (phase == 2) hold_start = 1;
      phase_target = $urandom_range(80, 200);
      phase_items = 0;
      while (phase_items < phase_target) begin
        if ($urandom_range(0, 9) == 0) begin
          push_beat(1'($urandom_range(0, 1)), SB'($urandom), SB'($urandom));
          phase_items++;
        end else begin
          span = (atk_len == 0) ? START_RAMP_LEN : ((atk_len > 200) ? 200 : int'(atk_len));
          run = $urandom_range(1, span + 8);
          push_beat(cacr_pkg::REQ_TRIGGER, SB'($urandom), SB'($urandom));
          repeat (run) push_beat(cacr_pkg::REQ_SAMPLE, pick_sample(), pick_sample());
          phase_items += run + 1;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
